@@ rtl/ptss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the periodic task slot scheduler.
// No dependencies; the interfaces and the top level import it.

package ptss_pkg;

	// Operation codes carried in the op field
	localparam logic [2:0] OP_ADD      = 3'd0;
	localparam logic [2:0] OP_DELETE   = 3'd1;
	localparam logic [2:0] OP_TICK     = 3'd2;
	localparam logic [2:0] OP_DISPATCH = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	localparam int TAG_W    = 16;
	localparam int TIME_W   = 32;
	localparam int RUNS_W   = 8;
	localparam int TICK_W   = 16;
	localparam int OP_W     = 3;
	localparam int SLOTO_W  = 3;

	// Results per dispatch transaction
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [RUNS_W-1:0] RUNS_MAX   = '1;
	localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1);

	typedef struct packed {
		logic [TAG_W-1:0]  task_tag;
		logic [TAG_W-1:0]  arg_tag;
		logic [TIME_W-1:0] countdown;
		logic [TIME_W-1:0] reload;
		logic [RUNS_W-1:0] runs;
	} slot_entry_t;

endpackage

`default_nettype wire

@@ rtl/ptss_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces of the scheduler: command, result, config.
// Depends on ptss_pkg for field widths.

interface ptss_in_if import ptss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [TAG_W-1:0]  task_tag;
	logic [TAG_W-1:0]  arg_tag;
	logic [TIME_W-1:0] start_delay;
	logic [TIME_W-1:0] period;

	modport source (output valid, op, task_tag, arg_tag, start_delay, period, input ready);
	modport sink (input valid, op, task_tag, arg_tag, start_delay, period, output ready);
endinterface

interface ptss_out_if import ptss_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SLOTO_W-1:0] slot;
	logic [TAG_W-1:0]   ready_task;
	logic [TAG_W-1:0]   ready_arg;
	logic               hit;
	logic               fault;
	logic               last;

	modport source (output valid, slot, ready_task, ready_arg, hit, fault, last, input ready);
	modport sink (input valid, slot, ready_task, ready_arg, hit, fault, last, output ready);
endinterface

interface ptss_cfg_if import ptss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/periodic_task_slot_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Periodic task slot scheduler: slot table, scan sequencer and result register.
// Depends on ptss_pkg and the channel interfaces in ptss_if.sv.
//
//   channel   dir   payload                                         role
//   in_ch     in    op, task_tag, arg_tag, start_delay, period      commands
//   out_ch    out   slot, ready_task, ready_arg, hit, fault, last   results
//   cfg_ch    in    data                                            tick_period write
//
// Add, delete, tick and dispatch scan the slot table one slot per cycle, unless a
// dispatch stalls, through one write port and one registered read port.
// Clear fault and unused op codes skip the scan and go straight to the done state.
// Reset clears the active bits, the fault flag and sets tick_period to 1.
// A dispatch pauses its scan at a further hit while a finished result waits on out_ch.

module periodic_task_slot_scheduler import ptss_pkg::*; #(
	parameter int NUM_SLOTS = 8
) (
	input  wire       clk,
	input  wire       arst_n,
	ptss_in_if.sink   in_ch,
	ptss_out_if.source out_ch,
	ptss_cfg_if.sink  cfg_ch
);

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	state_t             state_q;
	logic [TICK_W-1:0]  tick_q;
	logic               overflow_q;
	logic [NUM_SLOTS-1:0] active_q;

	logic [OP_W-1:0]    op_q;
	logic [TAG_W-1:0]   task_q;
	logic [TAG_W-1:0]   arg_q;
	logic [TIME_W-1:0]  delay_q;
	logic [TIME_W-1:0]  period_q;

	logic [SLOT_W-1:0]  addr_q;
	logic               issue_q;
	logic               found_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               v_s1;
	logic [SLOT_W-1:0]  idx_s1;
	slot_entry_t        rd_s1;

	// pending result, held until the next one shows whether it is the last
	logic               pend_v_q;
	logic [SLOTO_W-1:0] pend_slot_q;
	logic [TAG_W-1:0]   pend_task_q;
	logic [TAG_W-1:0]   pend_arg_q;

	logic               out_v_q;
	logic [SLOTO_W-1:0] out_slot_q;
	logic [TAG_W-1:0]   out_task_q;
	logic [TAG_W-1:0]   out_arg_q;
	logic               out_hit_q;
	logic               out_fault_q;
	logic               out_last_q;

	slot_entry_t        mem_q [NUM_SLOTS];

	logic               cur_act;
	logic               hit_now;
	logic               wr_en;
	slot_entry_t        wr_entry;
	logic               act_we;
	logic               act_val;
	logic               is_disp;
	logic               stall;
	logic               adv;
	logic               rd_en;
	logic               fault_fin;
	logic               in_acc;

	assign in_ch.ready   = (state_q == ST_IDLE);
	assign cfg_ch.ready  = 1'b1;
	assign in_acc        = in_ch.valid && in_ch.ready;

	assign out_ch.valid      = out_v_q;
	assign out_ch.slot       = out_slot_q;
	assign out_ch.ready_task = out_task_q;
	assign out_ch.ready_arg  = out_arg_q;
	assign out_ch.hit        = out_hit_q;
	assign out_ch.fault      = out_fault_q;
	assign out_ch.last       = out_last_q;

	assign cur_act = active_q[idx_s1];
	assign is_disp = (op_q == OP_DISPATCH);

	// Per-slot work of the shared compare/subtract unit
	always_comb begin
		hit_now  = 1'b0;
		wr_en    = 1'b0;
		wr_entry = rd_s1;
		act_we   = 1'b0;
		act_val  = 1'b0;
		unique case (op_q)
			OP_ADD: begin
				if (!found_q && (!cur_act || rd_s1.reload == '0)) begin
					hit_now            = 1'b1;
					wr_en              = 1'b1;
					wr_entry.task_tag  = task_q;
					wr_entry.arg_tag   = arg_q;
					wr_entry.countdown = delay_q;
					wr_entry.reload    = period_q;
					wr_entry.runs      = '0;
					act_we             = 1'b1;
					act_val            = 1'b1;
				end
			end
			OP_DELETE: begin
				if (!found_q && cur_act && rd_s1.task_tag == task_q
						&& rd_s1.arg_tag == arg_q) begin
					hit_now = 1'b1;
					act_we  = 1'b1;
				end
			end
			OP_TICK: begin
				if (cur_act) begin
					wr_en = 1'b1;
					if (rd_s1.countdown <= {{(TIME_W-TICK_W){1'b0}}, tick_q}) begin
						wr_entry.countdown = rd_s1.reload;
						if (rd_s1.runs != RUNS_MAX) begin
							wr_entry.runs = rd_s1.runs + RUNS_W'(1);
						end
					end else begin
						wr_entry.countdown = rd_s1.countdown - {{(TIME_W-TICK_W){1'b0}}, tick_q};
					end
				end
			end
			OP_DISPATCH: begin
				if (cur_act && rd_s1.runs != '0 && cnt_q < CNT_W'(MAX_RESULTS)) begin
					hit_now       = 1'b1;
					wr_en         = 1'b1;
					wr_entry.runs = rd_s1.runs - RUNS_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// a dispatch hit must first push the held result out
	assign stall = v_s1 && is_disp && hit_now && pend_v_q && out_v_q && !out_ch.ready;
	assign adv   = !stall;
	assign rd_en = (state_q == ST_SCAN) && issue_q && adv;

	always_comb begin
		unique case (op_q)
			OP_ADD:   fault_fin = overflow_q || !found_q;
			OP_CLEAR: fault_fin = 1'b0;
			default:  fault_fin = overflow_q;
		endcase
	end

	// Slot table: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && v_s1 && adv && wr_en) begin
			mem_q[idx_s1] <= wr_entry;
		end
		if (rd_en) begin
			rd_s1 <= mem_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tick_q     <= TICK_RESET;
			overflow_q <= 1'b0;
			active_q   <= '0;
			issue_q    <= 1'b0;
			found_q    <= 1'b0;
			cnt_q      <= '0;
			v_s1       <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				tick_q <= cfg_ch.data;
			end
			if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q     <= in_ch.op;
						task_q   <= in_ch.task_tag;
						arg_q    <= in_ch.arg_tag;
						delay_q  <= in_ch.start_delay;
						period_q <= in_ch.period;
						addr_q   <= '0;
						found_q  <= 1'b0;
						cnt_q    <= '0;
						pend_v_q <= 1'b0;
						if (in_ch.op == OP_ADD || in_ch.op == OP_DELETE
								|| in_ch.op == OP_TICK || in_ch.op == OP_DISPATCH) begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (!issue_q && !v_s1) begin
						state_q <= ST_DONE;
					end
					if (adv) begin
						if (issue_q) begin
							idx_s1 <= addr_q;
							v_s1   <= 1'b1;
							addr_q <= addr_q + SLOT_W'(1);
							if (addr_q == LAST_IDX) begin
								issue_q <= 1'b0;
							end
						end else begin
							v_s1 <= 1'b0;
						end
					end
					if (v_s1 && adv) begin
						if (act_we) begin
							active_q[idx_s1] <= act_val;
						end
						if (hit_now) begin
							found_q     <= 1'b1;
							pend_v_q    <= 1'b1;
							pend_slot_q <= SLOTO_W'(idx_s1);
							pend_task_q <= is_disp ? rd_s1.task_tag : '0;
							pend_arg_q  <= is_disp ? rd_s1.arg_tag : '0;
							if (is_disp) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
							// a later dispatch hit means the held one is not last
							if (is_disp && pend_v_q) begin
								out_v_q     <= 1'b1;
								out_slot_q  <= pend_slot_q;
								out_task_q  <= pend_task_q;
								out_arg_q   <= pend_arg_q;
								out_hit_q   <= 1'b1;
								out_fault_q <= overflow_q;
								out_last_q  <= 1'b0;
							end
						end
					end
				end
				ST_DONE: begin
					if (!out_v_q || out_ch.ready) begin
						out_v_q     <= 1'b1;
						out_slot_q  <= pend_v_q ? pend_slot_q : '0;
						out_task_q  <= pend_v_q ? pend_task_q : '0;
						out_arg_q   <= pend_v_q ? pend_arg_q : '0;
						out_hit_q   <= pend_v_q;
						out_fault_q <= fault_fin;
						out_last_q  <= 1'b1;
						overflow_q  <= fault_fin;
						pend_v_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("dispatch result count above limit");

	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !issue_q && !v_s1)
		else $error("scan pipeline not drained at finish");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ch.ready)
		else $error("command accepted while previous one in flight");

	a_single_hit_add: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && v_s1 && hit_now && !is_disp |-> !found_q)
		else $error("second slot claimed by add or delete");
`endif

endmodule

`default_nettype wire
